### hdl/ehpd_pkg.sv
// Shared types, codes and constants of the exception-header pointer decoder.
package ehpd_pkg;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_FMT  = 2'd1;
	localparam logic [1:0] ST_BAD_APPL = 2'd2;

	// Queue entry kinds.
	localparam logic [1:0] KIND_EMIT  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_BYTE  = 2'd2;

	// Fixed-width size codes.
	localparam logic [1:0] W16 = 2'd0;
	localparam logic [1:0] W32 = 2'd1;
	localparam logic [1:0] W64 = 2'd2;

	// Encoding byte fields and format codes.
	localparam logic [7:0] ENC_OMIT    = 8'hFF;
	localparam logic [2:0] APPL_ABS    = 3'd0;
	localparam logic [2:0] APPL_PCREL  = 3'd1;
	localparam logic [3:0] FMT_ABSPTR  = 4'h0;
	localparam logic [3:0] FMT_ULEB128 = 4'h1;
	localparam logic [3:0] FMT_UDATA2  = 4'h2;
	localparam logic [3:0] FMT_UDATA4  = 4'h3;
	localparam logic [3:0] FMT_UDATA8  = 4'h4;
	localparam logic [3:0] FMT_SLEB128 = 4'h9;
	localparam logic [3:0] FMT_SDATA2  = 4'hA;
	localparam logic [3:0] FMT_SDATA4  = 4'hB;
	localparam logic [3:0] FMT_SDATA8  = 4'hC;

	// LEB128 byte fields and the saturation point of the bit position.
	localparam logic [7:0] LEB_PAYLOAD = 8'h7F;
	localparam int         LEB_MORE    = 7;
	localparam int         LEB_SIGN    = 6;
	localparam logic [6:0] SHIFT_CAP   = 7'd70;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// One classified beat as it travels from front to back.
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic        leb;
		logic        sgn;
		logic [1:0]  wcode;
		logic        pc_rel;
		logic        indir;
		logic [63:0] base;
		logic [7:0]  data;
	} ehpd_entry_t;

endpackage

### hdl/ehpd_front.sv
// Front end: classifies each input beat into a queue entry.
module ehpd_front (
	input  logic                op,
	input  logic [7:0]          encoding,
	input  logic [63:0]         base_address,
	input  logic [7:0]          data_byte,
	output ehpd_pkg::ehpd_entry_t entry
);
	import ehpd_pkg::*;

	logic [3:0] fmt;
	logic [2:0] appl;
	logic       fmt_ok;

	assign fmt  = encoding[3:0];
	assign appl = encoding[6:4];

	// Decode the format into LEB, signedness and size.
	always_comb begin
		fmt_ok      = 1'b1;
		entry       = '0;
		entry.base  = base_address;
		entry.data  = data_byte;
		entry.indir = encoding[7];
		entry.pc_rel = (appl == APPL_PCREL);
		unique case (fmt)
			FMT_ABSPTR, FMT_UDATA8: entry.wcode = W64;
			FMT_UDATA2: entry.wcode = W16;
			FMT_UDATA4: entry.wcode = W32;
			FMT_SDATA8: begin
				entry.wcode = W64;
				entry.sgn   = 1'b1;
			end
			FMT_SDATA2: begin
				entry.wcode = W16;
				entry.sgn   = 1'b1;
			end
			FMT_SDATA4: begin
				entry.wcode = W32;
				entry.sgn   = 1'b1;
			end
			FMT_ULEB128: entry.leb = 1'b1;
			FMT_SLEB128: begin
				entry.leb = 1'b1;
				entry.sgn = 1'b1;
			end
			default: fmt_ok = 1'b0;
		endcase

		// Pick the kind; a data byte wins, then the omit encoding, then format, then application.
		priority if (op) begin
			entry.kind = KIND_BYTE;
		end else if (encoding == ENC_OMIT) begin
			entry.kind   = KIND_EMIT;
			entry.status = ST_OK;
		end else if (!fmt_ok) begin
			entry.kind   = KIND_EMIT;
			entry.status = ST_BAD_FMT;
		end else if (appl != APPL_ABS && appl != APPL_PCREL) begin
			entry.kind   = KIND_EMIT;
			entry.status = ST_BAD_APPL;
		end else begin
			entry.kind = KIND_START;
		end
	end

endmodule

### hdl/ehpd_queue.sv
// Short queue of classified beats between front and back.
module ehpd_queue #(
	parameter int Depth = ehpd_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ehpd_pkg::ehpd_entry_t wr_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output ehpd_pkg::ehpd_entry_t rd_entry
);
	import ehpd_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	ehpd_entry_t     mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == DepthCnt);
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/ehpd_back.sv
// Back end: gathers bytes into the pointer value and holds the result beat.
module ehpd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  ehpd_pkg::ehpd_entry_t q_entry,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           value,
	output logic                  indirect,
	output logic [1:0]            status
);
	import ehpd_pkg::*;

	// Decode state of the pointer in progress.
	logic        busy_q;
	logic        leb_q;
	logic        sgn_q;
	logic [1:0]  wcode_q;
	logic        pc_rel_q;
	logic        indir_q;
	logic [63:0] start_q;
	logic [63:0] acc_q;
	logic [6:0]  shift_q;

	// Result register.
	logic        out_valid_q;
	logic [63:0] value_q;
	logic        indirect_q;
	logic [1:0]  status_q;

	logic        advance;
	logic [6:0]  sh_fix;
	logic [6:0]  sh_sum;
	logic [6:0]  sh_leb;
	logic [6:0]  width;
	logic [63:0] acc_nx;
	logic [63:0] ext_mask;
	logic [63:0] final_v;
	logic        done;
	logic        is_byte;

	assign advance = !out_valid_q || !out_stall;
	assign q_pop   = q_valid && advance;
	assign is_byte = (q_entry.kind == KIND_BYTE) && busy_q;

	// Merge one byte into the accumulator and decide whether the value is complete.
	always_comb begin
		sh_fix   = {1'b0, shift_q[5:0]} + 7'd8;
		sh_sum   = shift_q + 7'd7;
		sh_leb   = (sh_sum > SHIFT_CAP) ? SHIFT_CAP : sh_sum;
		ext_mask = '0;
		unique case (wcode_q)
			W16:     width = 7'd16;
			W32:     width = 7'd32;
			default: width = 7'd64;
		endcase
		if (leb_q) begin
			acc_nx = acc_q;
			if (!shift_q[6]) begin
				acc_nx = acc_q | ({56'd0, q_entry.data & LEB_PAYLOAD} << shift_q[5:0]);
			end
			done = !q_entry.data[LEB_MORE];
			if (sgn_q && !sh_leb[6] && q_entry.data[LEB_SIGN]) begin
				ext_mask = {64{1'b1}} << sh_leb[5:0];
			end
		end else begin
			acc_nx = acc_q | ({56'd0, q_entry.data} << shift_q[5:0]);
			done   = (sh_fix >= width);
			if (sgn_q) begin
				unique case (wcode_q)
					W16:     ext_mask = acc_nx[15] ? {{48{1'b1}}, 16'd0} : '0;
					W32:     ext_mask = acc_nx[31] ? {{32{1'b1}}, 32'd0} : '0;
					default: ext_mask = '0;
				endcase
			end
		end
		final_v = (acc_nx | ext_mask) + (pc_rel_q ? start_q : 64'd0);
	end

	// Decode state update, one queue entry per cycle while the result register is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_pop) begin
			unique case (q_entry.kind)
				KIND_START: busy_q <= 1'b1;
				KIND_BYTE:  busy_q <= busy_q && !done;
				default:    busy_q <= 1'b0;
			endcase
		end
	end

	// Accumulator and format registers.
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.kind == KIND_START) begin
			leb_q    <= q_entry.leb;
			sgn_q    <= q_entry.sgn;
			wcode_q  <= q_entry.wcode;
			pc_rel_q <= q_entry.pc_rel;
			indir_q  <= q_entry.indir;
			start_q  <= q_entry.base;
			acc_q    <= '0;
			shift_q  <= '0;
		end else if (q_pop && is_byte) begin
			acc_q   <= acc_nx;
			shift_q <= leb_q ? sh_leb : sh_fix;
		end
	end

	// Result beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= q_valid &&
				((q_entry.kind == KIND_EMIT) || (is_byte && done));
		end
	end

	// Result beat payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_entry.kind == KIND_EMIT) begin
				value_q    <= '0;
				indirect_q <= 1'b0;
				status_q   <= q_entry.status;
			end else if (is_byte && done) begin
				value_q    <= final_v;
				indirect_q <= indir_q;
				status_q   <= ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign indirect  = indirect_q;
	assign status    = status_q;

endmodule

### hdl/eh_pointer_decoder.sv
// Top level of the exception-header encoded pointer decoder.
//
//   Channel  Direction  Handshake           Payload
//   in       to block   in_valid/in_stall   op, encoding, base_address, data_byte
//   out      from block out_valid/out_stall value, indirect, status
//
// One input beat per cycle is taken while the queue has room; the back end
// retires one queued beat per cycle whenever the result register is free.
// A result is registered in the result register when its closing beat is taken from the queue.
// Reset clears the queue, the busy flag and the result valid flag.
// A stall on the output fills the queue; in_stall rises once it is full.
module eh_pointer_decoder #(
	parameter int QUEUE_DEPTH = ehpd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  encoding,
	input  logic [63:0] base_address,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	output logic        indirect,
	output logic [1:0]  status
);
	import ehpd_pkg::*;

	ehpd_entry_t front_entry;
	ehpd_entry_t q_entry;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;

	assign in_stall = q_full;

	// Classification of incoming beats.
	ehpd_front u_front (
		.op           (op),
		.encoding     (encoding),
		.base_address (base_address),
		.data_byte    (data_byte),
		.entry        (front_entry)
	);

	// Decoupling queue.
	ehpd_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.wr_entry  (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_entry  (q_entry)
	);

	// Value assembly and result register.
	ehpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.indirect  (indirect),
		.status    (status)
	);

endmodule

### hdl/ehpd_checker.sv
// Port-level checks of the pointer decoder, bound to the top level.
module ehpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] value,
	input logic        indirect,
	input logic [1:0]  status
);
	import ehpd_pkg::*;

	// A stalled result beat stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value) && $stable(indirect) && $stable(status))
		else $error("result payload changed while stalled");

	// Only defined status codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_BAD_FMT || status == ST_BAD_APPL))
		else $error("undefined status code");

	// An error beat carries a zero value and no indirect flag.
	a_error_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> value == 64'd0 && !indirect)
		else $error("error beat with nonzero payload");

endmodule

bind eh_pointer_decoder ehpd_checker u_ehpd_checker (.*);
